[src/stmt_pkg.sv]
// ----------------------------------------------------------------------------
// stmt_pkg: shared types and constants for the sequence to MIDI track converter
// Holds the parse phases, the sequencer states, the error codes and the
// layout of the sideband word that travels with each track byte.
// ----------------------------------------------------------------------------
`default_nettype none

package stmt_pkg;

	// Parse phase of the compact sequence stream
	typedef enum logic [2:0] {
		PH_STATUS   = 3'd0,
		PH_DELAY_LO = 3'd1,
		PH_DELAY_HI = 3'd2,
		PH_DATA     = 3'd3,
		PH_SYSEX    = 3'd4,
		PH_ENDED    = 3'd5
	} ph_t;

	// Output sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DELTA,
		ST_EVENT,
		ST_SLEN,
		ST_SRD,
		ST_SOUT,
		ST_SEND
	} st_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_STATUS   = 2'd1,
		ERR_OVERFLOW = 2'd2
	} err_t;

	// Sideband word, packed from the lowest bit up: byte_valid, track_end, error_code
	typedef struct packed {
		err_t error_code;
		logic track_end;
		logic byte_valid;
	} out_user_t;

	localparam int unsigned USER_W  = $bits(out_user_t);
	localparam int unsigned DELTA_W = 28;
	localparam int unsigned CNT_W   = 6;

	localparam logic [7:0] BYTE_SOX  = 8'hF0;
	localparam logic [7:0] BYTE_END  = 8'hF2;
	localparam logic [7:0] BYTE_DLY1 = 8'hF3;
	localparam logic [7:0] BYTE_DLY2 = 8'hF4;
	localparam logic [7:0] BYTE_EOX  = 8'hF7;

	localparam logic [DELTA_W-1:0] DELTA_MAX = 28'hFFFFFFF;
	localparam logic [DELTA_W-1:0] VLQ_LIM3  = 28'h0200000;
	localparam logic [DELTA_W-1:0] VLQ_LIM2  = 28'h0004000;
	localparam logic [DELTA_W-1:0] VLQ_LIM1  = 28'h0000080;

	localparam out_user_t USER_DATA = '{error_code: ERR_NONE, track_end: 1'b0, byte_valid: 1'b1};

endpackage

`default_nettype wire

[src/stmt_sysex_ram.sv]
// ----------------------------------------------------------------------------
// stmt_sysex_ram: SysEx body buffer
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module stmt_sysex_ram #(
	parameter int unsigned DEPTH = 48,
	parameter int unsigned AW    = 6
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

[src/sequence_to_midi_track_converter.sv]
// ----------------------------------------------------------------------------
// sequence_to_midi_track_converter: compact sequence stream to MIDI track bytes
// Parses delay codes, channel events, SysEx and the end marker, and emits the
// track body with variable-length delta times.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis_* carries one sequence byte per transaction. m_axis_* carries one
//   track result per transaction: tdata is the track byte, tuser says whether
//   it is a real byte, the end marker or an error, and tlast closes the group
//   of results that one input byte caused.
// Sequencing:
//   Input bytes are taken only while the sequencer is idle, so a byte waits
//   until all results of the one before are loaded. A byte that yields no
//   result (delay codes, buffered SysEx body) leaves the sequencer idle. A
//   status byte first emits one delta byte per VLQ group (1 to 4). The flush
//   on F7 sends the length, then per buffered byte a read state and an output
//   state, as the buffer memory registers its read data, and last the F7.
// Reset:
//   arst_n clears the parse phase, delta, SysEx count and the output valid.
//   The body buffer is not cleared: it is only read at entries written since
//   the last F0.
// Backpressure:
//   A result waits in the output register while tready is low; the next
//   input byte is still taken, and the sequencer holds until the register
//   frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module sequence_to_midi_track_converter #(
	parameter int unsigned SYSEX_DEPTH = 48
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [7:0]                  s_axis_tdata,  // [7:0] data_byte
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	output logic [7:0]                       m_axis_tdata,  // [7:0] out_byte
	output logic                             m_axis_tlast,  // last
	output logic [stmt_pkg::USER_W-1:0]      m_axis_tuser   // [0] byte_valid,
	                                                        // [1] track_end,
	                                                        // [3:2] error_code
);

	localparam int unsigned AW = (SYSEX_DEPTH > 1) ? $clog2(SYSEX_DEPTH) : 1;
	localparam int unsigned CW = stmt_pkg::CNT_W;
	localparam int unsigned DW = stmt_pkg::DELTA_W;

	// Architectural parse state
	stmt_pkg::ph_t ph_q, ph_d;
	logic          long_q, long_d;
	logic [1:0]    left_q, left_d;
	logic [DW-1:0] delta_q, delta_d;
	logic [CW-1:0] cnt_q, cnt_d;

	// Output sequencer
	stmt_pkg::st_t       st_q, st_d;
	logic [1:0]          idx_q, idx_d;      // current delta group, high group first
	logic [CW-1:0]       ridx_q, ridx_d;    // SysEx flush read pointer
	logic [7:0]          ev_byte_q, ev_byte_d;
	stmt_pkg::out_user_t ev_user_q, ev_user_d;

	// Output register
	logic                m_valid_q;
	logic [7:0]          m_byte_q;
	logic                m_last_q;
	stmt_pkg::out_user_t m_user_q;

	logic                in_acc;
	logic                free;
	logic [7:0]          b;
	logic [14:0]         amount;
	logic [DW:0]         dsum;
	logic [DW-1:0]       dsat;
	logic [1:0]          vlq_top;
	logic [6:0]          grp;
	logic                wr_en;
	logic                rd_en;
	logic [7:0]          rd_data;
	logic                ld;
	logic [7:0]          ld_byte;
	logic                ld_last;
	stmt_pkg::out_user_t ld_user;

	assign b             = s_axis_tdata;
	assign s_axis_tready = (st_q == stmt_pkg::ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign free          = !m_valid_q || m_axis_tready;

	// Saturating delay accumulate: the second F4 operand is weighted by 128
	assign amount = (ph_q == stmt_pkg::PH_DELAY_HI) ? {b, 7'd0} : {7'd0, b};
	assign dsum   = {1'b0, delta_q} + {{(DW + 1 - 15){1'b0}}, amount};
	assign dsat   = (dsum >= {1'b0, stmt_pkg::DELTA_MAX}) ? stmt_pkg::DELTA_MAX : dsum[DW-1:0];

	// Number of VLQ groups minus one
	always_comb begin
		if (delta_q >= stmt_pkg::VLQ_LIM3) begin
			vlq_top = 2'd3;
		end else if (delta_q >= stmt_pkg::VLQ_LIM2) begin
			vlq_top = 2'd2;
		end else if (delta_q >= stmt_pkg::VLQ_LIM1) begin
			vlq_top = 2'd1;
		end else begin
			vlq_top = 2'd0;
		end
	end

	always_comb begin
		case (idx_q)
			2'd3:    grp = delta_q[27:21];
			2'd2:    grp = delta_q[20:14];
			2'd1:    grp = delta_q[13:7];
			default: grp = delta_q[6:0];
		endcase
	end

	// Next state
	always_comb begin
		st_d      = st_q;
		ph_d      = ph_q;
		long_d    = long_q;
		left_d    = left_q;
		delta_d   = delta_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		ridx_d    = ridx_q;
		ev_byte_d = ev_byte_q;
		ev_user_d = ev_user_q;
		wr_en     = 1'b0;
		unique case (st_q)
			stmt_pkg::ST_IDLE: begin
				if (in_acc) begin
					unique case (ph_q)
						stmt_pkg::PH_STATUS: begin
							if (b == stmt_pkg::BYTE_END) begin
								ph_d      = stmt_pkg::PH_ENDED;
								ev_byte_d = 8'd0;
								ev_user_d = '{error_code: stmt_pkg::ERR_NONE,
								              track_end: 1'b1, byte_valid: 1'b0};
								st_d      = stmt_pkg::ST_EVENT;
							end else if (b == stmt_pkg::BYTE_DLY1 || b == stmt_pkg::BYTE_DLY2) begin
								long_d = (b == stmt_pkg::BYTE_DLY2);
								ph_d   = stmt_pkg::PH_DELAY_LO;
							end else if (b == stmt_pkg::BYTE_SOX) begin
								ev_byte_d = b;
								ev_user_d = stmt_pkg::USER_DATA;
								cnt_d     = '0;
								idx_d     = vlq_top;
								ph_d      = stmt_pkg::PH_SYSEX;
								st_d      = stmt_pkg::ST_DELTA;
							end else begin
								case (b[7:4]) inside
									4'h8, 4'h9, 4'hA, 4'hB, 4'hE: begin
										ev_byte_d = b;
										ev_user_d = stmt_pkg::USER_DATA;
										left_d    = 2'd2;
										idx_d     = vlq_top;
										ph_d      = stmt_pkg::PH_DATA;
										st_d      = stmt_pkg::ST_DELTA;
									end
									4'hC, 4'hD: begin
										ev_byte_d = b;
										ev_user_d = stmt_pkg::USER_DATA;
										left_d    = 2'd1;
										idx_d     = vlq_top;
										ph_d      = stmt_pkg::PH_DATA;
										st_d      = stmt_pkg::ST_DELTA;
									end
									default: begin
										// unknown status: report and keep the delta
										ev_byte_d = 8'd0;
										ev_user_d = '{error_code: stmt_pkg::ERR_STATUS,
										              track_end: 1'b0, byte_valid: 1'b0};
										st_d      = stmt_pkg::ST_EVENT;
									end
								endcase
							end
						end
						stmt_pkg::PH_DELAY_LO: begin
							delta_d = dsat;
							ph_d    = long_q ? stmt_pkg::PH_DELAY_HI : stmt_pkg::PH_STATUS;
						end
						stmt_pkg::PH_DELAY_HI: begin
							delta_d = dsat;
							long_d  = 1'b0;
							ph_d    = stmt_pkg::PH_STATUS;
						end
						stmt_pkg::PH_DATA: begin
							ev_byte_d = b;
							ev_user_d = stmt_pkg::USER_DATA;
							left_d    = left_q - 2'd1;
							if (left_q == 2'd1) begin
								ph_d = stmt_pkg::PH_STATUS;
							end
							st_d      = stmt_pkg::ST_EVENT;
						end
						stmt_pkg::PH_SYSEX: begin
							if (b == stmt_pkg::BYTE_EOX) begin
								ph_d = stmt_pkg::PH_STATUS;
								st_d = stmt_pkg::ST_SLEN;
							end else if (({1'b0, cnt_q} + 7'd1) >= 7'(SYSEX_DEPTH)) begin
								// body full: drop the SysEx
								ev_byte_d = 8'd0;
								ev_user_d = '{error_code: stmt_pkg::ERR_OVERFLOW,
								              track_end: 1'b0, byte_valid: 1'b0};
								cnt_d     = '0;
								ph_d      = stmt_pkg::PH_STATUS;
								st_d      = stmt_pkg::ST_EVENT;
							end else begin
								wr_en = 1'b1;
								cnt_d = cnt_q + 1'b1;
							end
						end
						stmt_pkg::PH_ENDED: begin
						end
						default: begin
							ph_d = stmt_pkg::PH_STATUS;
						end
					endcase
				end
			end
			stmt_pkg::ST_DELTA: begin
				if (free) begin
					if (idx_q == 2'd0) begin
						delta_d = '0;
						st_d    = stmt_pkg::ST_EVENT;
					end else begin
						idx_d = idx_q - 2'd1;
					end
				end
			end
			stmt_pkg::ST_EVENT: begin
				if (free) begin
					st_d = stmt_pkg::ST_IDLE;
				end
			end
			stmt_pkg::ST_SLEN: begin
				if (free) begin
					ridx_d = '0;
					st_d   = (cnt_q == '0) ? stmt_pkg::ST_SEND : stmt_pkg::ST_SRD;
				end
			end
			stmt_pkg::ST_SRD: begin
				st_d = stmt_pkg::ST_SOUT;
			end
			stmt_pkg::ST_SOUT: begin
				if (free) begin
					ridx_d = ridx_q + 1'b1;
					st_d   = ((ridx_q + 1'b1) == cnt_q) ? stmt_pkg::ST_SEND : stmt_pkg::ST_SRD;
				end
			end
			stmt_pkg::ST_SEND: begin
				if (free) begin
					cnt_d = '0;
					st_d  = stmt_pkg::ST_IDLE;
				end
			end
			default: begin
				st_d = stmt_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer: what to load into the output register
	always_comb begin
		ld      = 1'b0;
		ld_byte = 8'd0;
		ld_last = 1'b0;
		ld_user = stmt_pkg::USER_DATA;
		rd_en   = 1'b0;
		unique case (st_q)
			stmt_pkg::ST_DELTA: begin
				ld      = free;
				ld_byte = {(idx_q != 2'd0), grp};
			end
			stmt_pkg::ST_EVENT: begin
				ld      = free;
				ld_byte = ev_byte_q;
				ld_user = ev_user_q;
				ld_last = 1'b1;
			end
			stmt_pkg::ST_SLEN: begin
				// body length counts the closing F7
				ld      = free;
				ld_byte = {1'b0, {1'b0, cnt_q} + 7'd1};
			end
			stmt_pkg::ST_SRD: begin
				rd_en = 1'b1;
			end
			stmt_pkg::ST_SOUT: begin
				ld      = free;
				ld_byte = rd_data;
			end
			stmt_pkg::ST_SEND: begin
				ld      = free;
				ld_byte = stmt_pkg::BYTE_EOX;
				ld_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= stmt_pkg::ST_IDLE;
			ph_q      <= stmt_pkg::PH_STATUS;
			long_q    <= 1'b0;
			left_q    <= 2'd0;
			delta_q   <= '0;
			cnt_q     <= '0;
			idx_q     <= 2'd0;
			ridx_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			st_q    <= st_d;
			ph_q    <= ph_d;
			long_q  <= long_d;
			left_q  <= left_d;
			delta_q <= delta_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			ridx_q  <= ridx_d;
			// hold the result until the receiver takes it
			if (ld) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		ev_byte_q <= ev_byte_d;
		ev_user_q <= ev_user_d;
		if (ld) begin
			m_byte_q <= ld_byte;
			m_user_q <= ld_user;
			m_last_q <= ld_last;
		end
	end

	stmt_sysex_ram #(
		.DEPTH (SYSEX_DEPTH),
		.AW    (AW)
	) u_sysex_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cnt_q[AW-1:0]),
		.wr_data (b),
		.rd_en   (rd_en),
		.rd_addr (ridx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_byte_q;
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tuser  = m_user_q;

endmodule

`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sequence to MIDI track converter
// Streams compact sequence bytes into the block and predicts every track
// result in the bench itself: delta VLQ bytes, copied channel events, SysEx
// flushes, errors and the end marker. Each output transaction is checked
// field by field against the oldest prediction. Both sides idle at random;
// the receiver also blocks for long stretches so the block backs up.
// ----------------------------------------------------------------------------

module tb;

	localparam int SYSEX_DEPTH = 48;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_ITEMS = 140;
	localparam int HOLD_CYCLES = 300;
	localparam int VLQ4_REPEATS = 64;

	// Channel event status codes (high nibble, channel in the low nibble)
	localparam logic [7:0] EV_NOTE_OFF = 8'h80;
	localparam logic [7:0] EV_NOTE_ON  = 8'h90;
	localparam logic [7:0] EV_POLY_AT  = 8'hA0;
	localparam logic [7:0] EV_CTRL     = 8'hB0;
	localparam logic [7:0] EV_PROG     = 8'hC0;
	localparam logic [7:0] EV_CHAN_AT  = 8'hD0;
	localparam logic [7:0] EV_BEND     = 8'hE0;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       tlast;
		logic       tend;
		stmt_pkg::err_t err;
	} track_res_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic m_axis_tlast;
	logic [stmt_pkg::USER_W-1:0] m_axis_tuser;

	logic [7:0] seq_bytes[$];      // input bytes still to be offered
	track_res_t track_expect[$];   // predicted track results, oldest first

	// Shadow of the block's parse state
	stmt_pkg::ph_t parse_ph = stmt_pkg::PH_STATUS;
	logic long_dly = 1'b0;
	logic [1:0] data_cnt = 2'd0;
	logic [stmt_pkg::DELTA_W-1:0] delta_acc = '0;
	logic [7:0] sx_body[SYSEX_DEPTH];
	logic [stmt_pkg::CNT_W-1:0] sx_len = '0;

	// Handshake bookkeeping, written at the rising edge, read at the falling edge
	logic seq_fire = 1'b0;
	logic res_fire = 1'b0;
	int bytes_in = 0;
	int results_seen = 0;
	int bad_results = 0;
	int tx_wait = 0;
	int rx_wait = 0;
	int hold_left = 0;
	logic held_once = 1'b0;
	int cycle_count = 0;

	sequence_to_midi_track_converter #(
		.SYSEX_DEPTH(SYSEX_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),     // [7:0] data_byte
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),     // [7:0] out_byte
		.m_axis_tlast(m_axis_tlast),     // last
		.m_axis_tuser(m_axis_tuser)      // [0] byte_valid, [1] track_end, [3:2] error_code
	);

	// ---------------------------------------------------------------- predictor

	function automatic void push_track(input logic [7:0] data, input logic valid,
			input logic tend, input stmt_pkg::err_t err);
		track_res_t r;
		r.data = valid ? data : 8'h00;
		r.valid = valid;
		r.tlast = 1'b0;
		r.tend = tend;
		r.err = err;
		track_expect.push_back(r);
	endfunction

	// Emit the running delta as a variable-length quantity, then clear it
	function automatic void emit_delta();
		logic [stmt_pkg::DELTA_W-1:0] v;
		v = delta_acc;
		if (v >= stmt_pkg::VLQ_LIM3)
			push_track({1'b1, v[27:21]}, 1'b1, 1'b0, stmt_pkg::ERR_NONE);
		if (v >= stmt_pkg::VLQ_LIM2)
			push_track({1'b1, v[20:14]}, 1'b1, 1'b0, stmt_pkg::ERR_NONE);
		if (v >= stmt_pkg::VLQ_LIM1)
			push_track({1'b1, v[13:7]}, 1'b1, 1'b0, stmt_pkg::ERR_NONE);
		push_track({1'b0, v[6:0]}, 1'b1, 1'b0, stmt_pkg::ERR_NONE);
		delta_acc = '0;
	endfunction

	// Add ticks to the delta, saturating at the 28-bit VLQ maximum
	function automatic void add_ticks(input logic [31:0] amount);
		logic [31:0] room;
		room = {4'd0, stmt_pkg::DELTA_MAX} - {4'd0, delta_acc};
		if (amount >= room) delta_acc = stmt_pkg::DELTA_MAX;
		else delta_acc = delta_acc + amount[stmt_pkg::DELTA_W-1:0];
	endfunction

	function automatic void take_status(input logic [7:0] b);
		if (b == stmt_pkg::BYTE_END) begin
			parse_ph = stmt_pkg::PH_ENDED;
			push_track(8'h00, 1'b0, 1'b1, stmt_pkg::ERR_NONE);
		end else if (b == stmt_pkg::BYTE_DLY1 || b == stmt_pkg::BYTE_DLY2) begin
			long_dly = (b == stmt_pkg::BYTE_DLY2);
			parse_ph = stmt_pkg::PH_DELAY_LO;
		end else if (b == stmt_pkg::BYTE_SOX) begin
			emit_delta();
			push_track(b, 1'b1, 1'b0, stmt_pkg::ERR_NONE);
			sx_len = '0;
			parse_ph = stmt_pkg::PH_SYSEX;
		end else begin
			case (b & 8'hF0)
				EV_NOTE_OFF, EV_NOTE_ON, EV_POLY_AT, EV_CTRL, EV_BEND: begin
					emit_delta();
					push_track(b, 1'b1, 1'b0, stmt_pkg::ERR_NONE);
					data_cnt = 2'd2;
					parse_ph = stmt_pkg::PH_DATA;
				end
				EV_PROG, EV_CHAN_AT: begin
					emit_delta();
					push_track(b, 1'b1, 1'b0, stmt_pkg::ERR_NONE);
					data_cnt = 2'd1;
					parse_ph = stmt_pkg::PH_DATA;
				end
				// Data bytes, F1, F5-FF and a stray F7 are not statuses; delta is kept
				default: push_track(8'h00, 1'b0, 1'b0, stmt_pkg::ERR_STATUS);
			endcase
		end
	endfunction

	function automatic void take_sysex(input logic [7:0] b);
		if (b == stmt_pkg::BYTE_EOX) begin
			// Length counts the body plus F7, then the body, then F7
			push_track({2'b00, sx_len} + 8'd1, 1'b1, 1'b0, stmt_pkg::ERR_NONE);
			for (int i = 0; i < int'(sx_len); i++)
				push_track(sx_body[i], 1'b1, 1'b0, stmt_pkg::ERR_NONE);
			push_track(stmt_pkg::BYTE_EOX, 1'b1, 1'b0, stmt_pkg::ERR_NONE);
			sx_len = '0;
			parse_ph = stmt_pkg::PH_STATUS;
		end else if (int'(sx_len) + 1 >= SYSEX_DEPTH) begin
			push_track(8'h00, 1'b0, 1'b0, stmt_pkg::ERR_OVERFLOW);
			sx_len = '0;
			parse_ph = stmt_pkg::PH_STATUS;
		end else begin
			sx_body[sx_len] = b;
			sx_len = sx_len + 1'b1;
		end
	endfunction

	// Predict the results of one accepted sequence byte
	function automatic void encode_byte(input logic [7:0] b);
		int n0;
		track_res_t r;
		n0 = track_expect.size();
		case (parse_ph)
			stmt_pkg::PH_STATUS: take_status(b);
			stmt_pkg::PH_DELAY_LO: begin
				add_ticks({24'd0, b});
				parse_ph = long_dly ? stmt_pkg::PH_DELAY_HI : stmt_pkg::PH_STATUS;
			end
			stmt_pkg::PH_DELAY_HI: begin
				add_ticks({17'd0, b, 7'd0});
				long_dly = 1'b0;
				parse_ph = stmt_pkg::PH_STATUS;
			end
			stmt_pkg::PH_DATA: begin
				push_track(b, 1'b1, 1'b0, stmt_pkg::ERR_NONE);
				data_cnt = data_cnt - 2'd1;
				if (data_cnt == 2'd0) parse_ph = stmt_pkg::PH_STATUS;
			end
			stmt_pkg::PH_SYSEX: take_sysex(b);
			stmt_pkg::PH_ENDED: ;
			default: parse_ph = stmt_pkg::PH_STATUS;
		endcase
		// Close the group of results this byte caused
		if (track_expect.size() > n0) begin
			r = track_expect.pop_back();
			r.tlast = 1'b1;
			track_expect.push_back(r);
		end
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic int draw_gap(input int mode);
		case (mode)
			0: return 0;
			1: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 17)) : 0;
			default: return $urandom_range(0, 17);
		endcase
	endfunction

	task automatic put_byte(input logic [7:0] b);
		seq_bytes.push_back(b);
	endtask

	// Push a SysEx body of random bytes, never the terminator
	task automatic put_sysex_body(input int n);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			b = 8'($urandom_range(0, 255));
			if (b == stmt_pkg::BYTE_EOX) b = 8'h00;
			put_byte(b);
		end
	endtask

	// Append one random event; every event leaves the parser expecting a status
	task automatic put_random_event();
		int pick;
		int n;
		logic [7:0] b;
		logic [7:0] chan;
		pick = $urandom_range(0, 99);
		chan = 8'($urandom_range(0, 15));
		if (pick < 30) begin
			case ($urandom_range(0, 4))
				0: b = EV_NOTE_OFF;
				1: b = EV_NOTE_ON;
				2: b = EV_POLY_AT;
				3: b = EV_CTRL;
				default: b = EV_BEND;
			endcase
			put_byte(b | chan);
			put_byte(8'($urandom_range(0, 255)));
			put_byte(8'($urandom_range(0, 255)));
		end else if (pick < 42) begin
			put_byte(($urandom_range(0, 1) ? EV_PROG : EV_CHAN_AT) | chan);
			put_byte(8'($urandom_range(0, 255)));
		end else if (pick < 57) begin
			put_byte(stmt_pkg::BYTE_DLY1);
			put_byte(8'($urandom_range(0, 255)));
		end else if (pick < 67) begin
			put_byte(stmt_pkg::BYTE_DLY2);
			put_byte(8'($urandom_range(0, 255)));
			put_byte(8'($urandom_range(0, 255)));
		end else if (pick < 80) begin
			put_byte(stmt_pkg::BYTE_SOX);
			put_sysex_body($urandom_range(0, 8));
			put_byte(stmt_pkg::BYTE_EOX);
		end else if (pick < 85) begin
			put_byte(stmt_pkg::BYTE_SOX);
			put_sysex_body($urandom_range(0, 1) ? SYSEX_DEPTH - 1 :
				int'($urandom_range(9, SYSEX_DEPTH - 1)));
			put_byte(stmt_pkg::BYTE_EOX);
		end else if (pick < 87) begin
			// Overflow the body buffer, then a stray terminator as a status
			put_byte(stmt_pkg::BYTE_SOX);
			put_sysex_body(SYSEX_DEPTH);
			if ($urandom_range(0, 1)) put_byte(stmt_pkg::BYTE_EOX);
		end else if (pick < 89) begin
			// Long rest: push the delta into the three-byte VLQ range
			n = $urandom_range(4, 12);
			for (int i = 0; i < n; i++) begin
				put_byte(stmt_pkg::BYTE_DLY2);
				put_byte(8'($urandom_range(128, 255)));
				put_byte(8'($urandom_range(128, 255)));
			end
		end else begin
			// Noise: a byte that is no valid status
			do b = 8'($urandom_range(0, 255));
			while ((b >= 8'h80 && b <= 8'hEF) || b == stmt_pkg::BYTE_SOX ||
				b == stmt_pkg::BYTE_END || b == stmt_pkg::BYTE_DLY1 ||
				b == stmt_pkg::BYTE_DLY2);
			put_byte(b);
		end
	endtask

	// ---------------------------------------------------------------- clock, reset

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'h00;
		m_axis_tready = 1'b0;
	end

	// ---------------------------------------------------------------- driver

	always @(negedge clk) begin
		if (arst_n) begin
			// Hold the current byte until its transaction completes
			if (!s_axis_tvalid || seq_fire) begin
				if (tx_wait > 0) begin
					s_axis_tvalid <= 1'b0;
					tx_wait--;
				end else if (seq_bytes.size() != 0) begin
					s_axis_tdata <= seq_bytes.pop_front();
					s_axis_tvalid <= 1'b1;
					tx_wait = draw_gap((bytes_in / 64) % 3);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	always @(negedge clk) begin
		if (arst_n) begin
			if (res_fire) rx_wait = draw_gap((results_seen / 48 + 1) % 3);
			if (hold_left != 0) begin
				m_axis_tready <= 1'b0;
			end else if (rx_wait > 0) begin
				m_axis_tready <= 1'b0;
				rx_wait--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Long receiver hold-off: once early for sure, then now and then at random
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
		end else if ((!held_once && bytes_in >= 40) || $urandom_range(0, 2999) == 0) begin
			held_once = 1'b1;
			hold_left = HOLD_CYCLES;
		end
	end

	// ---------------------------------------------------------------- monitor

	function automatic void check_field(input string what, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			bad_results++;
		end
	endfunction

	always @(posedge clk) begin
		stmt_pkg::out_user_t user;
		track_res_t want;
		seq_fire = s_axis_tvalid && s_axis_tready;
		res_fire = m_axis_tvalid && m_axis_tready;
		if (seq_fire) begin
			encode_byte(s_axis_tdata);
			bytes_in++;
		end
		if (res_fire) begin
			results_seen++;
			user = stmt_pkg::out_user_t'(m_axis_tuser);
			if (track_expect.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0h user %0h",
					$time, m_axis_tdata, m_axis_tuser);
				bad_results++;
			end else begin
				want = track_expect.pop_front();
				check_field("out_byte", want.data, m_axis_tdata);
				check_field("byte_valid", want.valid, user.byte_valid);
				check_field("last", want.tlast, m_axis_tlast);
				check_field("track_end", want.tend, user.track_end);
				check_field("error_code", want.err, user.error_code);
			end
		end
	end

	// ---------------------------------------------------------------- timeout

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		int rand_start;

		// Every kind of bad status; the delta stays at zero
		put_byte(8'h00); put_byte(8'h7F); put_byte(8'hF1);
		put_byte(8'hF5); put_byte(8'hFF); put_byte(stmt_pkg::BYTE_EOX);
		// One-byte VLQ extremes and the two-byte VLQ bottom, with three- and two-byte events
		put_byte(stmt_pkg::BYTE_DLY1); put_byte(8'h00);
		put_byte(EV_NOTE_ON); put_byte(8'h00); put_byte(8'h7F);
		put_byte(stmt_pkg::BYTE_DLY1); put_byte(8'h7F);
		put_byte(EV_PROG | 8'h05); put_byte(8'hFF);
		put_byte(stmt_pkg::BYTE_DLY1); put_byte(8'h80);
		put_byte(EV_CHAN_AT); put_byte(8'h80);
		// Two-byte VLQ top, three-byte VLQ bottom
		put_byte(stmt_pkg::BYTE_DLY2); put_byte(8'h7F); put_byte(8'h7F);
		put_byte(EV_BEND); put_byte(8'h01); put_byte(8'h02);
		put_byte(stmt_pkg::BYTE_DLY2); put_byte(8'h00); put_byte(8'h80);
		put_byte(EV_NOTE_OFF | 8'h0F); put_byte(8'h40); put_byte(8'h40);
		// End code as a delay operand, and a delta kept across a bad status
		put_byte(stmt_pkg::BYTE_DLY1); put_byte(stmt_pkg::BYTE_END);
		put_byte(8'h01);
		put_byte(EV_POLY_AT); put_byte(8'h12); put_byte(8'h34);
		put_byte(EV_CTRL | 8'h07); put_byte(8'h55); put_byte(8'h66);
		// Empty SysEx, and one whose body looks like statuses
		put_byte(stmt_pkg::BYTE_SOX); put_byte(stmt_pkg::BYTE_EOX);
		put_byte(stmt_pkg::BYTE_SOX); put_byte(stmt_pkg::BYTE_SOX);
		put_byte(stmt_pkg::BYTE_END);
		put_byte(EV_NOTE_ON); put_byte(stmt_pkg::BYTE_EOX);
		// Fullest SysEx body, then an overflow and a stray terminator
		put_byte(stmt_pkg::BYTE_SOX); put_sysex_body(SYSEX_DEPTH - 1);
		put_byte(stmt_pkg::BYTE_EOX);
		put_byte(stmt_pkg::BYTE_SOX); put_sysex_body(SYSEX_DEPTH);
		put_byte(stmt_pkg::BYTE_EOX);
		// Push the delta into the four-byte VLQ range, then flush it
		for (int i = 0; i < VLQ4_REPEATS; i++) begin
			put_byte(stmt_pkg::BYTE_DLY2); put_byte(8'hFF); put_byte(8'hFF);
		end
		put_byte(stmt_pkg::BYTE_DLY1); put_byte(8'hFF);
		put_byte(EV_NOTE_ON); put_byte(8'h3C); put_byte(8'h40);

		rand_start = seq_bytes.size();
		while (seq_bytes.size() - rand_start < RANDOM_ITEMS)
			put_random_event();

		// End the track; the bytes after it must be dropped
		put_byte(stmt_pkg::BYTE_END);
		put_byte(EV_NOTE_ON); put_byte(8'h3C); put_byte(stmt_pkg::BYTE_SOX);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (seq_bytes.size() != 0 || s_axis_tvalid) @(posedge clk);
		while (track_expect.size() != 0) @(posedge clk);
		// Let any stray result surface, outlasting a receiver hold-off
		repeat (HOLD_CYCLES + 200) @(posedge clk);

		if (bad_results == 0 && track_expect.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

[sequence_to_midi_track_converter.f]
src/stmt_pkg.sv
src/stmt_sysex_ram.sv
src/sequence_to_midi_track_converter.sv
verif/tb.sv
